// ===== src/wrf_pkg.sv =====
package wrf_pkg;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HALF    = 3;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_HEIGHT  = 4096;
    localparam int SIDE        = 2 * MAX_HALF + 1;
    localparam int LINES       = 2 * MAX_HALF;
    localparam int NWIN        = SIDE * SIDE;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int CNT_W       = $clog2(NWIN + 1);
    localparam int HALF_W      = 2;

    localparam logic [1:0] KIND_MEDIAN = 2'd0;
    localparam logic [1:0] KIND_MIN    = 2'd1;
    localparam logic [1:0] KIND_MAX    = 2'd2;

    localparam logic [1:0] REG_KIND   = 2'd0;
    localparam logic [1:0] REG_HALF   = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    typedef logic [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             done;
        logic [1:0]       kind;
        logic [HALF_W-1:0] half;
    } t_tag;
endpackage

// ===== src/wrf_line_mem.sv =====
module wrf_line_mem (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [wrf_pkg::COL_W-1:0]     i_rd_addr,
    output logic [wrf_pkg::LINES*wrf_pkg::SAMPLE_BITS-1:0] o_rd_data,
    input  logic                          i_wr_en,
    input  logic [wrf_pkg::COL_W-1:0]     i_wr_addr,
    input  logic [wrf_pkg::LINES*wrf_pkg::SAMPLE_BITS-1:0] i_wr_data
);
    logic [wrf_pkg::LINES*wrf_pkg::SAMPLE_BITS-1:0] mem [wrf_pkg::MAX_WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end
endmodule

// ===== src/wrf_rank.sv =====
// Rank selection over a window: counts are accumulated one window element per
// cycle against all candidates, then the candidate at the wanted rank is taken.
module wrf_rank (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  wrf_pkg::t_sample     i_win [wrf_pkg::NWIN],
    input  wrf_pkg::t_tag        i_tag,
    output logic                 o_busy,
    output logic                 o_done,
    output wrf_pkg::t_sample     o_value,
    output wrf_pkg::t_tag        o_tag
);
    localparam int IDX_W = $clog2(wrf_pkg::NWIN);

    logic                r_busy;
    logic [IDX_W-1:0]    r_j;
    wrf_pkg::t_sample    r_v [wrf_pkg::NWIN];
    logic                r_act [wrf_pkg::NWIN];
    logic [wrf_pkg::CNT_W-1:0] r_less [wrf_pkg::NWIN];
    logic [wrf_pkg::CNT_W-1:0] r_eq [wrf_pkg::NWIN];
    wrf_pkg::t_tag       r_tag;
    logic                r_done;
    logic [IDX_W-1:0]    r_last;
    logic [wrf_pkg::CNT_W-1:0] w_m;
    wrf_pkg::t_sample    w_pick;
    wrf_pkg::t_sample    w_vj;
    logic [wrf_pkg::CNT_W-1:0] w_lo;
    logic [2:0]          w_side;

    assign w_side = {r_tag.half, 1'b1};
    assign w_vj   = r_v[r_j];

    always_comb begin
        w_lo = '0;
        w_m = wrf_pkg::CNT_W'((32'(w_side) * 32'(w_side) - 1) / 2);
        unique case (r_tag.kind)
            wrf_pkg::KIND_MIN: w_m = '0;
            wrf_pkg::KIND_MAX: w_m = wrf_pkg::CNT_W'(32'(w_side) * 32'(w_side) - 1);
            default: w_m = wrf_pkg::CNT_W'((32'(w_side) * 32'(w_side) - 1) / 2);
        endcase
        w_pick = r_v[0];
        for (int i = wrf_pkg::NWIN - 1; i >= 0; i--) begin
            w_lo = r_less[i];
            if (r_act[i] && w_lo <= w_m && w_m < w_lo + r_eq[i]) begin
                w_pick = r_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_j    <= '0;
            end else if (r_busy) begin
                if (r_j == r_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_tag  <= i_tag;
            r_last <= IDX_W'(wrf_pkg::NWIN - 1);
            for (int i = 0; i < wrf_pkg::NWIN; i++) begin
                r_v[i]    <= i_win[i] ^ {1'b1, {(wrf_pkg::SAMPLE_BITS-1){1'b0}}};
                r_act[i]  <= (32'(i / wrf_pkg::SIDE) >= 32'(2*wrf_pkg::MAX_HALF) - 2*32'(i_tag.half))
                          && (32'(i % wrf_pkg::SIDE) >= 32'(2*wrf_pkg::MAX_HALF) - 2*32'(i_tag.half));
                r_less[i] <= '0;
                r_eq[i]   <= '0;
            end
        end else if (r_busy) begin
            for (int i = 0; i < wrf_pkg::NWIN; i++) begin
                if (r_act[r_j]) begin
                    if (w_vj < r_v[i]) r_less[i] <= r_less[i] + 1'b1;
                    else if (w_vj == r_v[i]) r_eq[i] <= r_eq[i] + 1'b1;
                end
            end
        end
    end

    assign o_busy  = r_busy || r_done;
    assign o_done  = r_done;
    assign o_value = w_pick ^ {1'b1, {(wrf_pkg::SAMPLE_BITS-1){1'b0}}};
    assign o_tag   = r_tag;
endmodule

// ===== src/window_rank_filter_core.sv =====
// Streaming 2-D median/min/max filter over a (2k+1)-square window. A pixel
// beat is not taken in the cycle after a beat: that cycle waits for
// the line memory data. A pixel that closes an interior window starts the rank
// unit (start, then all 49 window slots one per cycle, then done), so the
// next beat waits until the rank unit has finished. Border pixels start no rank.
// Results go to a two-deep output; the input also stalls while both are held.
module window_rank_filter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic signed [15:0] i_pixel,
    input  logic        i_frame_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_filtered,
    output logic [11:0] o_center_row,
    output logic [9:0]  o_center_col,
    output logic        o_frame_done
);
    localparam int LW = wrf_pkg::LINES * wrf_pkg::SAMPLE_BITS;

    logic [1:0]  r_kind;
    logic [1:0]  r_half;
    logic [10:0] r_width;
    logic [12:0] r_height;
    logic [wrf_pkg::ROW_W-1:0] r_row;
    logic [wrf_pkg::COL_W-1:0] r_col;

    logic        r_p1;
    wrf_pkg::t_sample r_p1_px;
    logic [wrf_pkg::COL_W-1:0] r_p1_col;
    logic        r_p1_emit;
    wrf_pkg::t_tag r_p1_tag;

    wrf_pkg::t_sample r_win [wrf_pkg::NWIN];
    logic [LW-1:0] w_rd;
    logic [LW-1:0] w_wr;

    logic        w_busy, w_done;
    wrf_pkg::t_sample w_val;
    wrf_pkg::t_tag w_tag;
    logic        r_ovalid;
    logic        r_hvalid;
    logic        w_ofire;
    logic        w_accept;

    logic [10:0] w_w;
    logic [12:0] w_h;
    logic [wrf_pkg::ROW_W-1:0] w_row;
    logic [wrf_pkg::COL_W-1:0] w_col;
    logic [12:0] n_row;
    logic [11:0] n_col;
    logic [12:0] w_row_x;
    logic [11:0] w_col_x;
    logic [3:0]  w_k2;
    logic        w_emit;

    assign w_w = (r_width == '0) ? 11'd1 : (r_width > 11'd1024 ? 11'd1024 : r_width);
    assign w_h = (r_height == '0) ? 13'd1 : (r_height > 13'd4096 ? 13'd4096 : r_height);
    assign w_row = i_frame_start ? '0 : r_row;
    assign w_col = i_frame_start ? '0 : r_col;
    assign w_row_x = {1'b0, w_row};
    assign w_col_x = {2'b0, w_col};
    assign w_k2 = {1'b0, r_half, 1'b0};
    assign w_emit = w_row_x >= 13'(w_k2) && w_col_x >= 12'(w_k2)
                 && w_row_x < w_h && w_col_x < 12'(w_w);

    // stall while ranking, while both output slots are full, or while the prior beat lands
    assign o_stall  = w_busy || r_p1 || r_hvalid;
    assign w_accept = i_valid && !o_stall;
    assign w_ofire  = r_ovalid && !i_stall;

    always_comb begin
        n_col = w_col_x + 12'd1;
        n_row = w_row_x;
        if (n_col >= 12'(w_w)) begin
            n_col = '0;
            n_row = w_row_x + 13'd1;
            if (n_row >= w_h) n_row = '0;
        end
    end

    wrf_line_mem u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_col),
        .o_rd_data (w_rd),
        .i_wr_en   (r_p1),
        .i_wr_addr (r_p1_col),
        .i_wr_data (w_wr)
    );

    assign w_wr = {w_rd[LW-wrf_pkg::SAMPLE_BITS-1:0], r_p1_px};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= wrf_pkg::KIND_MEDIAN;
            r_half <= 2'd1;
            r_width <= 11'd640;
            r_height <= 13'd480;
            r_row <= '0;
            r_col <= '0;
            r_p1 <= 1'b0;
            r_ovalid <= 1'b0;
            r_hvalid <= 1'b0;
            for (int i = 0; i < wrf_pkg::NWIN; i++) r_win[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    wrf_pkg::REG_KIND:   r_kind <= i_cfg_data[1:0];
                    wrf_pkg::REG_HALF:   r_half <= i_cfg_data[1:0];
                    wrf_pkg::REG_WIDTH:  r_width <= i_cfg_data[10:0];
                    wrf_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                endcase
            end
            r_p1 <= w_accept;
            if (w_accept) begin
                r_row <= n_row[wrf_pkg::ROW_W-1:0];
                r_col <= n_col[wrf_pkg::COL_W-1:0];
                r_p1_px <= i_pixel;
                r_p1_col <= w_col;
                r_p1_emit <= w_emit;
                r_p1_tag.row <= w_row - wrf_pkg::ROW_W'(r_half);
                r_p1_tag.col <= w_col - wrf_pkg::COL_W'(r_half);
                r_p1_tag.done <= (w_row_x == w_h - 13'd1) && (w_col_x == 12'(w_w) - 12'd1);
                r_p1_tag.kind <= r_kind;
                r_p1_tag.half <= r_half;
            end
            if (r_p1) begin
                for (int r = 0; r < wrf_pkg::SIDE; r++) begin
                    for (int c = 0; c + 1 < wrf_pkg::SIDE; c++)
                        r_win[r*wrf_pkg::SIDE+c] <= r_win[r*wrf_pkg::SIDE+c+1];
                end
                r_win[wrf_pkg::NWIN-1] <= r_p1_px;
                for (int i = 0; i < wrf_pkg::LINES; i++)
                    r_win[(wrf_pkg::SIDE-2-i)*wrf_pkg::SIDE+wrf_pkg::SIDE-1]
                        <= w_rd[i*wrf_pkg::SAMPLE_BITS +: wrf_pkg::SAMPLE_BITS];
            end
            // a rank starts only with the spare slot empty, so it is free at done
            if (w_done) begin
                if (!r_ovalid || w_ofire) r_ovalid <= 1'b1;
                else r_hvalid <= 1'b1;
            end else if (w_ofire) begin
                if (r_hvalid) r_hvalid <= 1'b0;
                else r_ovalid <= 1'b0;
            end
        end
    end

    logic r_start;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_start <= 1'b0;
        else r_start <= r_p1 && r_p1_emit;
    end

    wrf_pkg::t_tag r_s_tag;
    always_ff @(posedge i_clk) begin
        if (r_p1) r_s_tag <= r_p1_tag;
    end

    logic w_busy_r;
    wrf_rank u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_win   (r_win),
        .i_tag   (r_s_tag),
        .o_busy  (w_busy_r),
        .o_done  (w_done),
        .o_value (w_val),
        .o_tag   (w_tag)
    );
    assign w_busy = w_busy_r || r_start;

    wrf_pkg::t_sample r_oval;
    wrf_pkg::t_tag r_otag;
    wrf_pkg::t_sample r_hval;
    wrf_pkg::t_tag r_htag;
    always_ff @(posedge i_clk) begin
        if (w_done && (!r_ovalid || w_ofire)) begin
            r_oval <= w_val;
            r_otag <= w_tag;
        end else if (w_ofire && r_hvalid) begin
            r_oval <= r_hval;
            r_otag <= r_htag;
        end
        if (w_done && r_ovalid && !w_ofire) begin
            r_hval <= w_val;
            r_htag <= w_tag;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_filtered   = r_oval;
    assign o_center_row = r_otag.row;
    assign o_center_col = r_otag.col;
    assign o_frame_done = r_otag.done;
endmodule

// ===== verif/tb_window_rank_filter_core.sv =====
module tb_window_rank_filter_core;

    localparam int WATCHDOG = 5000;
    localparam int DRAIN    = 120;

    typedef struct {
        logic signed [15:0] pixel;
        logic               fs;
    } t_pix_beat;

    typedef struct {
        logic signed [15:0] filtered;
        logic [11:0]        row;
        logic [9:0]         col;
        logic               done;
    } t_rank_out;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = wrf_pkg::REG_KIND;
    logic [12:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_pixel = '0;
    logic               i_frame_start = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_filtered;
    logic [11:0]        o_center_row;
    logic [9:0]         o_center_col;
    logic               o_frame_done;

    window_rank_filter_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pixel      (i_pixel),
        .i_frame_start(i_frame_start),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_filtered   (o_filtered),
        .o_center_row (o_center_row),
        .o_center_col (o_center_col),
        .o_frame_done (o_frame_done)
    );

    always #5 i_clk = ~i_clk;

    // filter state mirror
    logic [1:0]         kind_reg = wrf_pkg::KIND_MEDIAN;
    logic [1:0]         half_reg = 2'd1;
    logic [10:0]        width_reg = 11'd640;
    logic [12:0]        height_reg = 13'd480;
    logic signed [15:0] line_mem [wrf_pkg::LINES][wrf_pkg::MAX_WIDTH];
    logic signed [15:0] win [wrf_pkg::SIDE][wrf_pkg::SIDE];
    int                 row_pos = 0;
    int                 col_pos = 0;

    t_pix_beat pixel_queue[$];
    t_rank_out pending_results[$];

    int  errors = 0;
    int  n_pixels = 0;
    int  n_results = 0;
    int  n_frames_done = 0;
    int  n_phases = 0;
    int  queued = 0;
    int  in_gap = 0;
    int  out_hold = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;
    bit  pressed = 1'b0;
    logic in_took = 1'b0;

    initial begin
        for (int i = 0; i < wrf_pkg::LINES; i++)
            for (int j = 0; j < wrf_pkg::MAX_WIDTH; j++)
                line_mem[i][j] = '0;
        for (int r = 0; r < wrf_pkg::SIDE; r++)
            for (int c = 0; c < wrf_pkg::SIDE; c++)
                win[r][c] = '0;
    end

    task automatic rank_window_step(input logic signed [15:0] px, input logic fs);
        int w, h, k, c, n, lo;
        logic signed [15:0] colv [wrf_pkg::SIDE];
        logic signed [15:0] vals [wrf_pkg::NWIN];
        logic signed [15:0] t, best;
        t_rank_out e;
        w = (width_reg == 0) ? 1 :
            (width_reg > wrf_pkg::MAX_WIDTH ? wrf_pkg::MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 :
            (height_reg > wrf_pkg::MAX_HEIGHT ? wrf_pkg::MAX_HEIGHT : height_reg);
        k = half_reg;
        if (fs) begin
            row_pos = 0;
            col_pos = 0;
        end
        c = (col_pos < wrf_pkg::MAX_WIDTH) ? col_pos : wrf_pkg::MAX_WIDTH - 1;
        colv[wrf_pkg::SIDE-1] = px;
        for (int i = 0; i < wrf_pkg::LINES; i++)
            colv[wrf_pkg::SIDE-2-i] = line_mem[i][c];
        for (int i = wrf_pkg::LINES - 1; i > 0; i--)
            line_mem[i][c] = line_mem[i-1][c];
        line_mem[0][c] = px;
        for (int r = 0; r < wrf_pkg::SIDE; r++) begin
            for (int i = 0; i < wrf_pkg::SIDE - 1; i++)
                win[r][i] = win[r][i+1];
            win[r][wrf_pkg::SIDE-1] = colv[r];
        end
        if (row_pos >= 2*k && col_pos >= 2*k && row_pos < h && col_pos < w) begin
            lo = 2*wrf_pkg::MAX_HALF - 2*k;
            n = 0;
            for (int r = lo; r < wrf_pkg::SIDE; r++)
                for (int cc = lo; cc < wrf_pkg::SIDE; cc++) begin
                    vals[n] = win[r][cc];
                    n++;
                end
            if (kind_reg == wrf_pkg::KIND_MIN || kind_reg == wrf_pkg::KIND_MAX) begin
                best = vals[0];
                for (int i = 1; i < n; i++)
                    if (kind_reg == wrf_pkg::KIND_MIN ? vals[i] < best : vals[i] > best)
                        best = vals[i];
            end else begin
                for (int i = 1; i < n; i++) begin
                    t = vals[i];
                    for (int j = i; j > 0; j--) begin
                        if (vals[j-1] > t) begin
                            vals[j] = vals[j-1];
                            vals[j-1] = t;
                        end
                    end
                end
                best = vals[(n-1)/2];
            end
            e.filtered = best;
            e.row = 12'(row_pos - k);
            e.col = 10'(col_pos - k);
            e.done = (row_pos == h - 1 && col_pos == w - 1);
            pending_results.push_back(e);
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    function automatic logic signed [15:0] pick_pixel(int style);
        case (style)
            1: return 16'($signed($urandom_range(4)) - 2);
            2: begin
                case ($urandom_range(4))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    3: return 16'shffff;
                    default: return 16'sh0001;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_pixel(input logic signed [15:0] px, input logic fs);
        t_pix_beat b;
        b.pixel = px;
        b.fs = fs;
        pixel_queue.push_back(b);
        queued++;
    endtask

    // whole frame, or cut short when cut is set; frame_start only on request
    task automatic push_frame(int w, int h, int style, bit fs, bit cut);
        int total;
        total = w * h;
        if (cut)
            total = $urandom_range(total > 1 ? total - 1 : 1, 1);
        for (int i = 0; i < total; i++)
            push_pixel(pick_pixel(style), fs && i == 0);
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (pixel_queue.size() != 0 || i_valid || pending_results.size() != 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 13'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            wrf_pkg::REG_KIND:  kind_reg = 2'(value);
            wrf_pkg::REG_HALF:  half_reg = 2'(value);
            wrf_pkg::REG_WIDTH: width_reg = 11'(value);
            default:            height_reg = 13'(value);
        endcase
    endtask

    // input side
    always @(posedge i_clk) begin
        in_took <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            rank_window_step(i_pixel, i_frame_start);
            n_pixels++;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_took)) begin
            if (in_gap > 0) begin
                in_gap--;
                i_valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
                t_pix_beat b;
                b = pixel_queue.pop_front();
                i_pixel <= b.pixel;
                i_frame_start <= b.fs;
                i_valid <= 1'b1;
                in_gap = pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output side
    always @(negedge i_clk) begin
        int r;
        if (!pressed && n_results >= 150) begin
            pressed = 1'b1;
            out_hold = 400;
        end
        if (out_hold > 0) begin
            out_hold--;
            i_stall <= 1'b1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else begin
            r = $urandom_range(99);
            if (r < 60) begin
                i_stall <= 1'b0;
            end else if (r < 90) begin
                i_stall <= 1'b1;
            end else if (r < 97) begin
                out_hold = $urandom_range(5, 2);
                i_stall <= 1'b1;
            end else begin
                out_hold = $urandom_range(80, 20);
                i_stall <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_rank_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: filtered %0d row %0d col %0d",
                       o_filtered, o_center_row, o_center_col);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_frame_done) n_frames_done++;
                if (o_filtered !== e.filtered) begin
                    $error("filtered: expected %0d, got %0d", e.filtered, o_filtered);
                    errors++;
                end
                if (o_center_row !== e.row) begin
                    $error("center_row: expected %0d, got %0d", e.row, o_center_row);
                    errors++;
                end
                if (o_center_col !== e.col) begin
                    $error("center_col: expected %0d, got %0d", e.col, o_center_col);
                    errors++;
                end
                if (o_frame_done !== e.done) begin
                    $error("frame_done: expected %0d, got %0d", e.done, o_frame_done);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("timeout: no beat for %0d cycles", WATCHDOG);
            $display("window_rank_filter_core regression: fail");
            $finish;
        end
    end

    initial begin
        int k, w, h, nfr;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // 1x1 frames through saturated-to-one sizes, kind three acting as median
        write_reg(wrf_pkg::REG_KIND, 3);
        write_reg(wrf_pkg::REG_HALF, 0);
        write_reg(wrf_pkg::REG_WIDTH, 0);
        write_reg(wrf_pkg::REG_HEIGHT, 0);
        push_pixel(16'sh7fff, 1'b1);
        push_pixel(16'sh8000, 1'b0);
        push_pixel(16'sh0000, 1'b0);
        push_pixel(16'shffff, 1'b0);
        wait_idle();

        write_reg(wrf_pkg::REG_KIND, wrf_pkg::KIND_MIN);
        write_reg(wrf_pkg::REG_HALF, 1);
        write_reg(wrf_pkg::REG_WIDTH, 3);
        write_reg(wrf_pkg::REG_HEIGHT, 3);
        push_frame(3, 3, 2, 1'b1, 1'b0);
        wait_idle();
        write_reg(wrf_pkg::REG_KIND, wrf_pkg::KIND_MAX);
        push_frame(3, 3, 2, 1'b1, 1'b0);
        wait_idle();

        // oversize registers saturate; partial frame
        write_reg(wrf_pkg::REG_HALF, 0);
        write_reg(wrf_pkg::REG_WIDTH, 2047);
        write_reg(wrf_pkg::REG_HEIGHT, 8191);
        push_frame(1024, 1, 0, 1'b1, 1'b1);
        wait_idle();
        write_reg(wrf_pkg::REG_HALF, 3);
        write_reg(wrf_pkg::REG_WIDTH, 7);
        write_reg(wrf_pkg::REG_HEIGHT, 7);
        write_reg(wrf_pkg::REG_KIND, wrf_pkg::KIND_MEDIAN);
        push_frame(7, 7, 0, 1'b1, 1'b0);
        wait_idle();

        while (queued < 1050) begin
            n_phases++;
            quiet = ($urandom_range(3) == 0);
            k = $urandom_range(3);
            if ($urandom_range(9) == 0) begin
                w = $urandom_range(2*k + 1, 1);
                h = $urandom_range(2*k + 1, 1);
            end else begin
                w = $urandom_range(2*k + 5, 2*k + 1);
                h = $urandom_range(2*k + 4, 2*k + 1);
            end
            write_reg(wrf_pkg::REG_KIND, $urandom_range(3));
            write_reg(wrf_pkg::REG_HALF, k);
            write_reg(wrf_pkg::REG_WIDTH, w);
            write_reg(wrf_pkg::REG_HEIGHT, h);
            nfr = $urandom_range(3, 1);
            for (int f = 0; f < nfr; f++)
                push_frame(w, h, $urandom_range(2), f == 0 || $urandom_range(1),
                           $urandom_range(7) == 0);
            wait_idle();
        end
        quiet = 1'b0;
        wait_idle();

        $display("%0d pixels in, %0d results checked over %0d random phases",
                 n_pixels, n_results, n_phases);
        $display("%0d frame ends seen; median, min and max over window sides 1 to 7",
                 n_frames_done);
        if (errors == 0)
            $display("window_rank_filter_core regression: pass");
        else
            $display("window_rank_filter_core regression: fail");
        $finish;
    end
endmodule
